>>> design/ntpc_pkg.sv
// ============================================================================
// ntpc_pkg
// Shared types, TLV codes, category codes and name literals for the
// NDN TLV packet classifier.
// ============================================================================
package ntpc_pkg;

    localparam int LEN_W = 16;
    localparam int PW    = LEN_W + 1;
    localparam int SW    = 33;

    typedef logic [2:0] t_cat;

    localparam t_cat CAT_DV       = 3'd0;
    localparam t_cat CAT_PSYNC    = 3'd1;
    localparam t_cat CAT_MGMT     = 3'd2;
    localparam t_cat CAT_INTEREST = 3'd3;
    localparam t_cat CAT_DATA     = 3'd4;
    localparam t_cat CAT_OTHER    = 3'd5;

    localparam logic [31:0] TLV_INTEREST = 32'h05;
    localparam logic [31:0] TLV_DATA     = 32'h06;
    localparam logic [31:0] TLV_NAME     = 32'h07;
    localparam logic [31:0] TLV_GENERIC  = 32'h08;
    localparam logic [31:0] TLV_KEYWORD  = 32'h20;
    localparam logic [31:0] TLV_LP       = 32'h64;
    localparam logic [31:0] TLV_FRAG     = 32'h50;

    localparam logic [7:0] NUM_2B = 8'd253;
    localparam logic [7:0] NUM_4B = 8'd254;

    localparam int LIT_N = 5;
    localparam int LIT_LOCALHOST = 0;
    localparam int LIT_NLSR      = 1;
    localparam int LIT_DV        = 2;
    localparam int LIT_PFS       = 3;
    localparam int LIT_PES       = 4;

    localparam int NF_LOCALHOST = 0;
    localparam int NF_NLSR      = 1;
    localparam int NF_DV        = 2;
    localparam int NF_PSYNC     = 3;
    localparam int NF_INTEREST  = 4;

    localparam logic [3:0] LIT_LEN [LIT_N] = '{4'd9, 4'd4, 4'd2, 4'd3, 4'd3};
    localparam logic [71:0] LIT_TEXT [LIT_N] = '{
        72'("localhost"),
        {32'("nlsr"), 40'h0},
        {16'("DV"), 56'h0},
        {24'("PFS"), 48'h0},
        {24'("PES"), 48'h0}
    };

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             first_byte;
        logic [LEN_W-1:0] packet_length;
        logic             last_byte;
    } t_item;

    function automatic logic f_lit_hit(input int idx, input logic [3:0] off,
                                       input logic [7:0] b);
        logic [3:0]  k;
        logic [71:0] txt;
        logic        hit;
        hit = 1'b0;
        txt = LIT_TEXT[idx];
        if (off < LIT_LEN[idx]) begin
            k   = 4'd8 - off;
            hit = (txt[8*k +: 8] == b);
        end
        return hit;
    endfunction

endpackage

>>> design/ntpc_parser.sv
// ============================================================================
// ntpc_parser
// Per-byte TLV parse state: number decode, LP unwrap, name component walk
// and category decision, one byte per step.
// ============================================================================
module ntpc_parser import ntpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    output t_cat  o_category
);

    typedef enum logic [3:0] {
        PH_OUTER, PH_LP_LEN, PH_LP_FTYPE, PH_LP_FLEN, PH_LP_SKIP, PH_INNER,
        PH_PKT_LEN, PH_NAME_TYPE, PH_NAME_LEN, PH_COMP_TYPE, PH_COMP_LEN,
        PH_COMP_VALUE, PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [31:0]      acc;
        logic [3:0]       nbl;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] lp_end;
        logic [LEN_W-1:0] reg_end;
        logic [LEN_W-1:0] name_end;
        logic [LEN_W-1:0] comp_end;
        logic [LEN_W-1:0] skip;
        logic [1:0]       ccount;
        logic [4:0]       lmf;
        logic [4:0]       nf;
        t_cat             cat;
        logic [1:0]       kind;
        logic             frag;
        logic             disc;
        logic [3:0]       voff;
    } t_pst;

    function automatic t_pst f_start(input logic [LEN_W-1:0] len);
        t_pst s;
        s         = '0;
        s.phase   = PH_OUTER;
        s.reg_end = len;
        s.lmf     = 5'h1f;
        s.cat     = CAT_OTHER;
        return s;
    endfunction

    function automatic t_pst f_other(input t_pst s_in);
        t_pst s;
        s       = s_in;
        s.cat   = CAT_OTHER;
        s.phase = PH_DONE;
        return s;
    endfunction

    function automatic t_pst f_decide(input t_pst s_in);
        t_pst s;
        s = s_in;
        priority if (s.nf[NF_LOCALHOST] && s.nf[NF_NLSR]) s.cat = CAT_MGMT;
        else if (s.nf[NF_DV] && s.nf[NF_PSYNC])          s.cat = CAT_PSYNC;
        else if (s.nf[NF_DV])                            s.cat = CAT_DV;
        else if (s.nf[NF_INTEREST])                      s.cat = CAT_INTEREST;
        else                                             s.cat = CAT_DATA;
        s.phase = PH_DONE;
        return s;
    endfunction

    function automatic logic [LEN_W-1:0] f_bound(input t_pst s);
        logic [LEN_W-1:0] bnd;
        unique case (s.phase)
            PH_LP_FTYPE, PH_LP_FLEN:  bnd = s.lp_end;
            PH_COMP_TYPE, PH_COMP_LEN: bnd = s.name_end;
            default:                   bnd = s.reg_end;
        endcase
        return bnd;
    endfunction

    function automatic t_pst f_finish(input t_pst s_in, input logic [31:0] v);
        t_pst        s;
        logic [SW-1:0] sum;
        s   = s_in;
        sum = SW'(s.pos) + SW'(v);
        unique case (s.phase)
            PH_OUTER, PH_INNER: begin
                if (v == TLV_INTEREST || v == TLV_DATA) begin
                    if (v == TLV_INTEREST) s.nf[NF_INTEREST] = 1'b1;
                    s.phase = PH_PKT_LEN;
                end else if (s.phase == PH_OUTER && v == TLV_LP) begin
                    s.phase = PH_LP_LEN;
                end else begin
                    s = f_other(s);
                end
            end
            PH_LP_LEN: begin
                if (sum > SW'(s.reg_end)) s = f_other(s);
                else begin
                    s.lp_end = sum[LEN_W-1:0];
                    s.phase  = PH_LP_FTYPE;
                end
            end
            PH_LP_FTYPE: begin
                s.frag  = (v == TLV_FRAG);
                s.phase = PH_LP_FLEN;
            end
            PH_LP_FLEN: begin
                if (sum > SW'(s.lp_end)) s = f_other(s);
                else if (s.frag) begin
                    s.reg_end = sum[LEN_W-1:0];
                    s.phase   = PH_INNER;
                end else begin
                    s.skip  = sum[LEN_W-1:0];
                    s.phase = PH_LP_SKIP;
                end
            end
            PH_PKT_LEN: s.phase = PH_NAME_TYPE;
            PH_NAME_TYPE: begin
                if (v == TLV_NAME) s.phase = PH_NAME_LEN;
                else s = f_other(s);
            end
            PH_NAME_LEN: begin
                if (sum > SW'(s.reg_end)) s = f_other(s);
                else begin
                    s.name_end = sum[LEN_W-1:0];
                    s.ccount   = 2'd0;
                    s.phase    = PH_COMP_TYPE;
                end
            end
            PH_COMP_TYPE: begin
                s.kind  = (v == TLV_GENERIC) ? 2'd1 : ((v == TLV_KEYWORD) ? 2'd2 : 2'd0);
                s.phase = PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
                if (sum > SW'(s.name_end)) s = f_decide(s);
                else begin
                    s.comp_end = sum[LEN_W-1:0];
                    for (int i = 0; i < LIT_N; i++)
                        s.lmf[i] = (v == 32'(LIT_LEN[i]));
                    s.voff  = 4'd0;
                    s.phase = PH_COMP_VALUE;
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_pst f_end_comp(input t_pst s_in);
        t_pst s;
        s = s_in;
        if (s.ccount == 2'd0 && s.kind == 2'd1 && s.lmf[LIT_LOCALHOST])
            s.nf[NF_LOCALHOST] = 1'b1;
        else if (s.ccount == 2'd1 && s.nf[NF_LOCALHOST] && s.kind == 2'd1
                 && s.lmf[LIT_NLSR])
            s.nf[NF_NLSR] = 1'b1;
        if (s.kind == 2'd2) begin
            if (s.lmf[LIT_DV]) s.nf[NF_DV] = 1'b1;
            if (s.lmf[LIT_PFS] || s.lmf[LIT_PES]) s.nf[NF_PSYNC] = 1'b1;
        end
        if (s.ccount != 2'd3) s.ccount = s.ccount + 2'd1;
        s.phase = PH_COMP_TYPE;
        return s;
    endfunction

    // one byte-less step; no change once settled
    function automatic t_pst f_settle(input t_pst s_in);
        t_pst s;
        s = s_in;
        unique case (s.phase)
            PH_DONE: ;
            PH_LP_SKIP: if (s.pos >= s.skip) s.phase = PH_LP_FTYPE;
            PH_COMP_VALUE: if (s.pos >= s.comp_end) s = f_end_comp(s);
            default: begin
                if (s.nbl == 4'd0 && s.pos >= f_bound(s)) begin
                    if (s.phase == PH_LP_FTYPE || s.phase == PH_NAME_TYPE) s = f_other(s);
                    else if (s.phase == PH_COMP_TYPE) s = f_decide(s);
                    else s = f_finish(s, 32'd0);
                end
            end
        endcase
        return s;
    endfunction

    function automatic t_pst f_consume(input t_pst s_in, input logic [7:0] b);
        t_pst        s;
        logic [3:0]  need;
        logic [PW-1:0] pn;
        logic [31:0] acc_n;
        s = s_in;
        unique case (s.phase)
            PH_DONE: ;
            PH_LP_SKIP: s.pos = s.pos + LEN_W'(1);
            PH_COMP_VALUE: begin
                for (int i = 0; i < LIT_N; i++)
                    if (!f_lit_hit(i, s.voff, b)) s.lmf[i] = 1'b0;
                if (s.voff != 4'd15) s.voff = s.voff + 4'd1;
                s.pos = s.pos + LEN_W'(1);
            end
            default: begin
                s.pos = s.pos + LEN_W'(1);
                if (s.nbl != 4'd0) begin
                    acc_n = s.disc ? s.acc : {s.acc[23:0], b};
                    s.acc = acc_n;
                    s.nbl = s.nbl - 4'd1;
                    if (s.nbl == 4'd0) s = f_finish(s, s.disc ? 32'd0 : acc_n);
                end else if (b < NUM_2B) begin
                    s = f_finish(s, 32'(b));
                end else begin
                    need = (b == NUM_2B) ? 4'd2 : ((b == NUM_4B) ? 4'd4 : 4'd8);
                    pn   = PW'(s.pos) + PW'(need);
                    if (pn > PW'(f_bound(s))) s = f_finish(s, 32'd0);
                    else begin
                        s.acc  = 32'd0;
                        s.nbl  = need;
                        s.disc = (b == 8'hff);
                    end
                end
            end
        endcase
        return s;
    endfunction

    t_pst r_st;
    t_pst n_st;
    t_pst s_pre;
    t_pst s_post;

    always_comb begin
        s_pre  = i_item.first_byte ? f_settle(f_start(i_item.packet_length)) : r_st;
        s_post = f_consume(s_pre, i_item.data_byte);
        s_post = f_settle(s_post);
        s_post = f_settle(s_post);
        s_post = f_settle(s_post);
        s_post = f_settle(s_post);
        o_category = (s_post.phase == PH_DONE) ? s_post.cat : CAT_OTHER;
        n_st = i_item.last_byte ? f_other(s_post) : s_post;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_other(f_start('0));
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule

>>> design/ndn_tlv_packet_classifier.sv
// ============================================================================
// ndn_tlv_packet_classifier
// Classifies one NDN TLV packet per byte stream into a traffic category.
// ============================================================================
// Input channel: one packet byte per request (i_in_valid / o_in_stall), with
// first_byte and packet_length on the packet's opening byte and last_byte on
// its closing byte. Output channel: one category per packet
// (o_out_valid / i_out_stall), produced for the request carrying last_byte.
// Throughput: one byte per cycle while the input is not stalled. The category
// is registered: the last byte is accepted into the input register, and is
// then parsed into the result register once the receiver can take it.
// The parse state advances as each byte leaves the input register.
// When the receiver stalls, the result register holds; non-final bytes keep
// flowing, and only a final byte waits in the input register, which then
// stalls the sender. Reset (synchronous, active low) empties both registers
// and leaves the parser in a finished state, so bytes arriving without a
// first-byte mark classify as other.
// ============================================================================
module ndn_tlv_packet_classifier import ntpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_first_byte,
    input  logic [LEN_W-1:0] i_packet_length,
    input  logic             i_last_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_category
);

    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;
    t_cat  r_cat;
    logic  w_step;
    t_cat  w_cat;

    assign w_step     = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;

    ntpc_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_item     (r_in),
        .o_category (w_cat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in        <= '0;
            r_cat       <= CAT_OTHER;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in.data_byte     <= i_data_byte;
                    r_in.first_byte    <= i_first_byte;
                    r_in.packet_length <= i_packet_length;
                    r_in.last_byte     <= i_last_byte;
                end
            end
            if (w_step && r_in.last_byte) begin
                r_out_valid <= 1'b1;
                r_cat       <= w_cat;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_category  = r_cat;

    a_cat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_category <= CAT_OTHER)
        else $error("category out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in.last_byte && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.last_byte) |=> (o_out_valid && o_category == $past(w_cat)))
        else $error("final byte did not produce a result");

endmodule

>>> sim/tb_ndn_tlv_packet_classifier.sv
// ============================================================================
// tb_ndn_tlv_packet_classifier
// Self-checking bench: streams directed and random NDN TLV packets byte by
// byte, predicts the category of each one, and checks every result in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_ndn_tlv_packet_classifier;
    import ntpc_pkg::*;

    typedef enum logic [3:0] {
        PH_OUTER, PH_LP_LEN, PH_LP_FTYPE, PH_LP_FLEN, PH_LP_SKIP, PH_INNER,
        PH_PKT_LEN, PH_NAME_TYPE, PH_NAME_LEN, PH_COMP_TYPE, PH_COMP_LEN,
        PH_COMP_VALUE, PH_DONE
    } t_phase;

    localparam int KIND_OTHER   = 0;
    localparam int KIND_GENERIC = 1;
    localparam int KIND_KEYWORD = 2;
    localparam int LIMIT_CYCLES = 400000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_data_byte;
    logic             i_first_byte;
    logic [LEN_W-1:0] i_packet_length;
    logic             i_last_byte;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [2:0]       o_category;

    ndn_tlv_packet_classifier u_top (.*);

    string lit_txt [LIT_N] = '{"localhost", "nlsr", "DV", "PFS", "PES"};

    t_item request_q [$];
    t_cat  category_q [$];
    int    err_cnt;
    int    cycle_cnt;
    int    total_count;

    // ---------------- category predictor ----------------
    t_phase      ph;
    logic [31:0] acc;
    logic [3:0]  nleft;
    logic [63:0] pos, lp_end, reg_end, nm_end, comp_end, skip_tgt;
    logic [1:0]  ccount;
    logic [4:0]  lit_ok, nflags;
    t_cat        cat;
    int          kind;
    bit          frag, discard;
    logic [3:0]  voff;
    t_cat        pred_cat;

    function void give_other();
        cat = CAT_OTHER;
        ph  = PH_DONE;
    endfunction

    function void decide();
        if (nflags[NF_LOCALHOST] && nflags[NF_NLSR]) cat = CAT_MGMT;
        else if (nflags[NF_DV] && nflags[NF_PSYNC]) cat = CAT_PSYNC;
        else if (nflags[NF_DV]) cat = CAT_DV;
        else cat = nflags[NF_INTEREST] ? CAT_INTEREST : CAT_DATA;
        ph = PH_DONE;
    endfunction

    function logic [63:0] bound(t_phase p);
        case (p)
            PH_LP_FTYPE, PH_LP_FLEN:  return lp_end;
            PH_COMP_TYPE, PH_COMP_LEN: return nm_end;
            default:                   return reg_end;
        endcase
    endfunction

    function void take_type(logic [63:0] v, bit wrap);
        if (v == TLV_INTEREST || v == TLV_DATA) begin
            if (v == TLV_INTEREST) nflags[NF_INTEREST] = 1'b1;
            ph = PH_PKT_LEN;
        end else if (wrap && v == TLV_LP) begin
            ph = PH_LP_LEN;
        end else begin
            give_other();
        end
    endfunction

    function void finish_num(logic [63:0] v);
        case (ph)
            PH_OUTER: take_type(v, 1'b1);
            PH_INNER: take_type(v, 1'b0);
            PH_LP_LEN: begin
                if (pos + v > reg_end) give_other();
                else begin
                    lp_end = pos + v;
                    ph = PH_LP_FTYPE;
                end
            end
            PH_LP_FTYPE: begin
                frag = (v == TLV_FRAG);
                ph = PH_LP_FLEN;
            end
            PH_LP_FLEN: begin
                if (pos + v > lp_end) give_other();
                else if (frag) begin
                    reg_end = pos + v;
                    ph = PH_INNER;
                end else begin
                    skip_tgt = pos + v;
                    ph = PH_LP_SKIP;
                end
            end
            PH_PKT_LEN: ph = PH_NAME_TYPE;
            PH_NAME_TYPE: begin
                if (v == TLV_NAME) ph = PH_NAME_LEN;
                else give_other();
            end
            PH_NAME_LEN: begin
                if (pos + v > reg_end) give_other();
                else begin
                    nm_end = pos + v;
                    ccount = 0;
                    ph = PH_COMP_TYPE;
                end
            end
            PH_COMP_TYPE: begin
                kind = (v == TLV_GENERIC) ? KIND_GENERIC :
                       (v == TLV_KEYWORD) ? KIND_KEYWORD : KIND_OTHER;
                ph = PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
                if (pos + v > nm_end) decide();
                else begin
                    comp_end = pos + v;
                    for (int i = 0; i < LIT_N; i++)
                        lit_ok[i] = (v == lit_txt[i].len());
                    voff = 0;
                    ph = PH_COMP_VALUE;
                end
            end
            default: ;
        endcase
    endfunction

    function void end_comp();
        if (ccount == 0 && kind == KIND_GENERIC && lit_ok[LIT_LOCALHOST])
            nflags[NF_LOCALHOST] = 1'b1;
        else if (ccount == 1 && nflags[NF_LOCALHOST] && kind == KIND_GENERIC
                 && lit_ok[LIT_NLSR])
            nflags[NF_NLSR] = 1'b1;
        if (kind == KIND_KEYWORD) begin
            if (lit_ok[LIT_DV]) nflags[NF_DV] = 1'b1;
            if (lit_ok[LIT_PFS] || lit_ok[LIT_PES]) nflags[NF_PSYNC] = 1'b1;
        end
        if (ccount < 3) ccount++;
        ph = PH_COMP_TYPE;
    endfunction

    function void settle();
        for (int g = 0; g < 64; g++) begin
            if (ph == PH_DONE) return;
            if (ph == PH_LP_SKIP) begin
                if (pos < skip_tgt) return;
                ph = PH_LP_FTYPE;
            end else if (ph == PH_COMP_VALUE) begin
                if (pos < comp_end) return;
                end_comp();
            end else if (nleft != 0 || pos < bound(ph)) begin
                return;
            end else if (ph == PH_LP_FTYPE || ph == PH_NAME_TYPE) begin
                give_other();
            end else if (ph == PH_COMP_TYPE) begin
                decide();
            end else begin
                finish_num(0);
            end
        end
    endfunction

    function void consume(logic [7:0] b);
        logic [3:0] need;
        if (ph == PH_LP_SKIP) begin
            pos = (pos + 1) & 64'hFFFF;
            return;
        end
        if (ph == PH_COMP_VALUE) begin
            for (int i = 0; i < LIT_N; i++)
                if (lit_ok[i] && (voff >= lit_txt[i].len() || lit_txt[i][voff] != b))
                    lit_ok[i] = 1'b0;
            if (voff < 15) voff++;
            pos = (pos + 1) & 64'hFFFF;
            return;
        end
        if (ph == PH_DONE || ph > PH_COMP_LEN) return;
        pos = (pos + 1) & 64'hFFFF;
        if (nleft != 0) begin
            if (!discard) acc = {acc[23:0], b};
            nleft--;
            if (nleft == 0) finish_num(discard ? 64'd0 : {32'd0, acc});
            return;
        end
        if (b < NUM_2B) begin
            finish_num({56'd0, b});
            return;
        end
        need = (b == NUM_2B) ? 4'd2 : (b == NUM_4B) ? 4'd4 : 4'd8;
        if (pos + need > bound(ph)) begin
            finish_num(0);
            return;
        end
        acc = 0;
        nleft = need;
        discard = (b == 8'd255);
    endfunction

    function void pkt_start(logic [LEN_W-1:0] len);
        ph = PH_OUTER;
        acc = 0; nleft = 0; pos = 0; lp_end = 0; reg_end = len;
        nm_end = 0; comp_end = 0; ccount = 0; lit_ok = '1; nflags = 0;
        cat = CAT_OTHER; skip_tgt = 0; kind = KIND_OTHER;
        frag = 0; discard = 0; voff = 0;
    endfunction

    function bit classify_byte(t_item it);
        if (it.first_byte) pkt_start(it.packet_length);
        settle();
        consume(it.data_byte);
        settle();
        if (it.last_byte) begin
            pred_cat = (ph == PH_DONE) ? cat : CAT_OTHER;
            give_other();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------- packet builders ----------------
    function automatic void put_num(ref logic [7:0] q[$], input int unsigned v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            q.push_back(8'd255);
            repeat (4) q.push_back(8'd0);
            for (int i = 3; i >= 0; i--) q.push_back(8'(v >> (8 * i)));
        end else if (v < 253 && r < 80) begin
            q.push_back(8'(v));
        end else if (v < 65536 && r < 92) begin
            q.push_back(NUM_2B);
            q.push_back(8'(v >> 8));
            q.push_back(8'(v));
        end else begin
            q.push_back(NUM_4B);
            for (int i = 3; i >= 0; i--) q.push_back(8'(v >> (8 * i)));
        end
    endfunction

    function automatic void put_tlv(ref logic [7:0] q[$], input int unsigned t,
                                    ref logic [7:0] body[$]);
        int unsigned len;
        len = body.size();
        if ($urandom_range(0, 19) == 0) len = len + $urandom_range(0, 6) - 3;
        put_num(q, t);
        put_num(q, len);
        foreach (body[i]) q.push_back(body[i]);
    endfunction

    function automatic void put_comp(ref logic [7:0] q[$], input int idx);
        logic [7:0] v [$];
        int unsigned t;
        int sel;
        sel = $urandom_range(0, 9);
        if (idx == 0 && $urandom_range(0, 2) == 0) sel = LIT_LOCALHOST;
        if (sel < LIT_N) begin
            for (int i = 0; i < lit_txt[sel].len(); i++) v.push_back(lit_txt[sel][i]);
            if ($urandom_range(0, 9) == 0) v[$urandom_range(0, v.size() - 1)] ^= 8'h01;
        end else begin
            repeat ($urandom_range(0, 5)) v.push_back(8'($urandom));
        end
        case ($urandom_range(0, 9))
            0:       t = $urandom_range(0, 255);
            1, 2, 3: t = TLV_KEYWORD;
            default: t = (sel == LIT_DV || sel >= LIT_PFS) && sel < LIT_N
                         ? TLV_KEYWORD : TLV_GENERIC;
        endcase
        put_tlv(q, t, v);
    endfunction

    function automatic void add_packet();
        logic [7:0] pkt [$], comps [$], nm [$], inner [$], body [$], fld [$];
        int unsigned plen;
        int cut;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end else begin
            for (int i = 0; i < $urandom_range(0, 4); i++) put_comp(comps, i);
            put_tlv(nm, ($urandom_range(0, 19) == 0) ? 8'($urandom) : TLV_NAME, comps);
            foreach (nm[i]) body.push_back(nm[i]);
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
            put_tlv(inner, $urandom_range(0, 1) ? TLV_INTEREST : TLV_DATA, body);
            if ($urandom_range(0, 9) < 3) begin
                body.delete();
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(0, 3)) fld.push_back(8'($urandom));
                    put_tlv(body, $urandom_range(0, 'h60), fld);
                end
                put_tlv(body, ($urandom_range(0, 9) == 0) ? 8'($urandom) : TLV_FRAG, inner);
                put_tlv(pkt, TLV_LP, body);
            end else begin
                pkt = inner;
            end
        end
        plen = pkt.size();
        case ($urandom_range(0, 19))
            0:       plen = $urandom_range(0, 65535);
            1:       plen = $urandom_range(0, plen + 3);
            default: ;
        endcase
        cut = pkt.size();
        if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, pkt.size());
        else if ($urandom_range(0, 19) == 0) cut = pkt.size() + $urandom_range(1, 3);
        for (int i = 0; i < cut; i++) begin
            t_item it;
            it.data_byte     = (i < pkt.size()) ? pkt[i] : 8'($urandom);
            it.first_byte    = (i == 0) && ($urandom_range(0, 19) != 0);
            it.packet_length = (i == 0) ? LEN_W'(plen) : LEN_W'($urandom);
            it.last_byte     = (i == cut - 1);
            request_q.push_back(it);
        end
    endfunction

    function automatic void add_bytes(input logic [7:0] b [$], input int unsigned plen,
                                      input bit first);
        foreach (b[i]) begin
            t_item it;
            it.data_byte     = b[i];
            it.first_byte    = first && (i == 0);
            it.packet_length = LEN_W'(plen);
            it.last_byte     = (i == b.size() - 1);
            request_q.push_back(it);
        end
    endfunction

    // ---------------- clock, reset, stimulus ----------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial total_count = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) total_count <= total_count + 1;
    end

    initial begin
        int total;
        i_rst_n = 1'b0;
        err_cnt = 0;
        pkt_start(0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_bytes('{8'h05}, 0, 1'b1);
        add_bytes('{8'h06, 8'h02}, 2, 1'b0);
        add_bytes('{8'h05, 8'h0B, 8'h07, 8'h09, 8'h20, 8'h02, 8'h44, 8'h56,
                    8'h20, 8'h03, 8'h50, 8'h45, 8'h53}, 13, 1'b1);
        add_bytes('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h05}, 16'hFFFF, 1'b1);
        @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || category_q.size() != 0)
            @(negedge i_clk);

        total = total_count + request_q.size();
        while (total < 1300) begin
            add_packet();
            total = total_count + request_q.size();
        end

        @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || category_q.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && category_q.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // ---------------- request driver ----------------
    t_item cur;
    int    burst_left;
    int    gap_left;

    initial begin
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_first_byte    = 1'b0;
        i_packet_length = '0;
        i_last_byte     = 1'b0;
        burst_left      = 0;
        gap_left        = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (classify_byte(cur)) category_q.push_back(pred_cat);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0 || request_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    cur = request_q.pop_front();
                    i_data_byte     <= cur.data_byte;
                    i_first_byte    <= cur.first_byte;
                    i_packet_length <= cur.packet_length;
                    i_last_byte     <= cur.last_byte;
                    i_in_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ---------------- result monitor ----------------
    int stall_pct;

    initial begin
        i_out_stall = 1'b0;
        stall_pct   = 0;
    end

    always @(posedge i_clk) begin
        if (cycle_cnt % 300 == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                2:       stall_pct = 70;
                default: stall_pct = 95;
            endcase
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (category_q.size() == 0) begin
                $display("%0t: unexpected category, expected none, actual %0d",
                         $realtime, o_category);
                err_cnt++;
            end else begin
                t_cat want;
                want = category_q.pop_front();
                if (o_category !== want) begin
                    $display("%0t: category mismatch, expected %0d, actual %0d",
                             $realtime, want, o_category);
                    err_cnt++;
                end
            end
        end
    end

    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
